@@ hdl/ssg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment packer package
// Item types, font table and character lookup for the text packer.
// ----------------------------------------------------------------------------
package ssg_pkg;

    localparam int unsigned C_MAX_DIGITS = 4;
    localparam int unsigned C_WORDS      = 3;

    localparam logic [7:0] C_CHAR_DOT   = 8'h2E;
    localparam logic [7:0] C_CHAR_MINUS = 8'h2D;
    localparam logic [7:0] C_CHAR_AMP   = 8'h26;
    localparam logic [7:0] C_CHAR_NUL   = 8'h00;

    localparam logic [5:0] C_IDX_DOT   = 6'd36;
    localparam logic [5:0] C_IDX_MINUS = 6'd37;
    localparam logic [5:0] C_IDX_SPEC  = 6'd38;
    localparam logic [5:0] C_IDX_AMP   = 6'd47;
    localparam logic [5:0] C_IDX_ALPHA = 6'd10;

    typedef logic [2:0] t_digit_count;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_of_text;
    } t_in_item;

    typedef struct packed {
        logic [15:0] word_zero;
        logic [15:0] word_one;
        logic [15:0] word_two;
    } t_out_item;

    // Segment bits: 0 top, 1 top right, 2 bottom right, 3 bottom,
    // 4 bottom left, 5 top left, 6 middle, 7 dot.
    localparam logic [7:0] C_FONT [48] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7C, 8'h07, 8'h7F, 8'h67,
        8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h30, 8'h1E,
        8'h75, 8'h38, 8'h15, 8'h37, 8'h3F, 8'h73, 8'h6B, 8'h33, 8'h6D, 8'h78,
        8'h3E, 8'h3E, 8'h2A, 8'h76, 8'h6E, 8'h5B,
        8'h80, 8'h40,
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h09, 8'h5D, 8'h5C,
        8'h49
    };

    // Map one text byte to its segment pattern; unmapped bytes are blank.
    function automatic logic [7:0] glyph_of(input logic [7:0] c);
        logic [7:0] off_num;
        logic [7:0] off_up;
        logic [7:0] off_lo;
        logic [7:0] off_sp;
        logic [7:0] g;
        off_num = c - 8'h30;
        off_up  = c - 8'h41;
        off_lo  = c - 8'h61;
        off_sp  = c - 8'h01;
        if (c >= 8'h30 && c <= 8'h39) begin
            g = C_FONT[off_num[5:0]];
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            g = C_FONT[off_up[5:0] + C_IDX_ALPHA];
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            g = C_FONT[off_lo[5:0] + C_IDX_ALPHA];
        end else if (c == C_CHAR_DOT) begin
            g = C_FONT[C_IDX_DOT];
        end else if (c == C_CHAR_MINUS) begin
            g = C_FONT[C_IDX_MINUS];
        end else if (c == C_CHAR_AMP) begin
            g = C_FONT[C_IDX_AMP];
        end else if (c >= 8'h01 && c <= 8'h09) begin
            g = C_FONT[off_sp[5:0] + C_IDX_SPEC];
        end else begin
            g = 8'h00;
        end
        return g;
    endfunction

    // OR mask that places a pattern into digit d of the three words.
    function automatic t_out_item place_digit(input logic [1:0] d, input logic [7:0] pat);
        t_out_item m;
        m = '0;
        case (d)
            2'd0: begin
                m.word_zero[7:0] = pat;
            end
            2'd1: begin
                m.word_zero[15:8] = pat;
            end
            2'd2: begin
                m.word_one[7:0] = pat;
            end
            default: begin
                m.word_two[7:0] = pat;
            end
        endcase
        return m;
    endfunction

endpackage

@@ hdl/ssg_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready channel
// One item moves at a clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface ssg_stream_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/seven_segment_text_packer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment text packer
// Packs a byte stream of text into three 16-bit display words.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle and turns in one result item per
// text, on the cycle after the byte marked last_of_text is taken. Each byte
// goes through the font lookup and one OR into the word buffer between the
// state registers and the result register, so a new item is taken every
// cycle; input ready drops only while a result is held and the sink is not
// taking it. Digit 1 lands in word_zero[7:0], digit 2 in word_zero[15:8],
// digit 3 in word_one[7:0] and digit 4 in word_two[7:0]. A '.' right after
// a placed character sets that digit's dot, also after the last digit.
// Placement stops at digit_count digits (values above 4 act as 4) or at a
// zero byte. digit_count resets to 4; the user writes it through i_cfg only while
// no text is in flight; the block does not enforce it. The buffer clears after each text.
// ----------------------------------------------------------------------------
module seven_segment_text_packer
    import ssg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    ssg_stream_if.sink   i_cfg,
    ssg_stream_if.sink   i_text,
    ssg_stream_if.source o_words
);

    // Text state
    logic [2:0]   r_pos,   n_pos;
    logic         r_dot,   n_dot;
    logic         r_ended, n_ended;
    t_out_item    r_words, n_words;
    t_digit_count r_digit_count;

    // Result register
    logic      r_out_valid, n_out_valid;
    t_out_item r_out,       n_out;

    logic       w_in_acc;
    logic [2:0] w_limit;
    logic [7:0] w_char;
    logic [2:0] w_pos_m1;
    t_out_item  w_mask;

    // Configuration is taken at any time; the user writes it only while idle.
    assign i_cfg.ready = 1'b1;

    // Hold input while a result waits for the sink.
    assign i_text.ready  = !r_out_valid || o_words.ready;
    assign w_in_acc      = i_text.valid && i_text.ready;
    assign o_words.valid = r_out_valid;
    assign o_words.payload = r_out;

    assign w_char   = i_text.payload.char_code;
    assign w_limit  = (r_digit_count > 3'(C_MAX_DIGITS)) ? 3'(C_MAX_DIGITS) : r_digit_count;
    assign w_pos_m1 = r_pos - 3'd1;

    // Next text state for the accepted byte.
    always_comb begin
        n_pos   = r_pos;
        n_dot   = r_dot;
        n_ended = r_ended;
        w_mask  = '0;
        if (!r_ended) begin
            if (w_char == C_CHAR_NUL) begin
                n_ended = 1'b1;
                n_dot   = 1'b0;
            end else if (r_dot && w_char == C_CHAR_DOT) begin
                // Merge the dot into the digit just placed.
                if (r_pos != 3'd0) begin
                    w_mask = place_digit(w_pos_m1[1:0], C_FONT[C_IDX_DOT]);
                end
                n_dot = 1'b0;
                if (r_pos >= w_limit) begin
                    n_ended = 1'b1;
                end
            end else if (r_pos < w_limit) begin
                w_mask = place_digit(r_pos[1:0], glyph_of(w_char));
                n_pos  = r_pos + 3'd1;
                n_dot  = 1'b1;
            end else begin
                n_ended = 1'b1;
                n_dot   = 1'b0;
            end
        end
        n_words = r_words | w_mask;
    end

    // Result register: load on a last item, drop once the sink takes it.
    always_comb begin
        n_out_valid = r_out_valid && !o_words.ready;
        n_out       = r_out;
        if (w_in_acc && i_text.payload.last_of_text) begin
            n_out_valid = 1'b1;
            n_out       = n_words;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_dot         <= 1'b0;
            r_ended       <= 1'b0;
            r_words       <= '0;
            r_digit_count <= 3'(C_MAX_DIGITS);
            r_out_valid   <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_digit_count <= i_cfg.payload;
            end
            if (w_in_acc) begin
                if (i_text.payload.last_of_text) begin
                    // Clear the buffer for the next text.
                    r_pos   <= '0;
                    r_dot   <= 1'b0;
                    r_ended <= 1'b0;
                    r_words <= '0;
                end else begin
                    r_pos   <= n_pos;
                    r_dot   <= n_dot;
                    r_ended <= n_ended;
                    r_words <= n_words;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

@@ hdl/ssg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment packer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module ssg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_text_valid,
    input logic        i_text_ready,
    input logic        i_text_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_word_one,
    input logic [15:0] i_word_two
);

    logic w_last_acc;
    assign w_last_acc = i_text_valid && i_text_ready && i_text_last;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_word_one)
            && $stable(i_word_two))
        else $error("stalled result changed");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_acc |=> i_out_valid)
        else $error("no result after last item");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(w_last_acc))
        else $error("result without a last item");

    a_high_bytes_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_word_one[15:8] == 8'h00 && i_word_two[15:8] == 8'h00)
        else $error("unused digit byte set");

endmodule

bind seven_segment_text_packer ssg_checker u_ssg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_text_valid (i_text.valid),
    .i_text_ready (i_text.ready),
    .i_text_last  (i_text.payload.last_of_text),
    .i_out_valid  (o_words.valid),
    .i_out_ready  (o_words.ready),
    .i_word_one   (o_words.payload.word_one),
    .i_word_two   (o_words.payload.word_two)
);
